@@ src/clns_pkg.sv @@
// Shared types and constants for the character LCD nibble sequencer.
// Used by the controller, the datapath and the top level; depends on nothing.
package clns_pkg;

    localparam logic [7:0] EXPANDER_ADDRESS_RESET = 8'h4E;

    localparam logic [3:0] SH_RS = 4'h1;
    localparam logic [3:0] SH_RW = 4'h2;
    localparam logic [3:0] SH_E  = 4'h4;
    localparam logic [3:0] SH_BL = 4'h8;

    localparam logic [2:0] OP_INIT      = 3'd0;
    localparam logic [2:0] OP_COMMAND   = 3'd1;
    localparam logic [2:0] OP_DATA      = 3'd2;
    localparam logic [2:0] OP_POSITION  = 3'd3;
    localparam logic [2:0] OP_BACKLIGHT = 3'd4;
    localparam logic [2:0] OP_CLEAR     = 3'd5;

    localparam logic [2:0] K_NONE  = 3'd0;
    localparam logic [2:0] K_INIT  = 3'd1;
    localparam logic [2:0] K_CMD   = 3'd2;
    localparam logic [2:0] K_DATA  = 3'd3;
    localparam logic [2:0] K_BL    = 3'd4;
    localparam logic [2:0] K_CLEAR = 3'd5;

    localparam logic [2:0] W_RS      = 3'd0;
    localparam logic [2:0] W_ERISE   = 3'd1;
    localparam logic [2:0] W_PUT     = 3'd2;
    localparam logic [2:0] W_EFALL   = 3'd3;
    localparam logic [2:0] W_BL_ITEM = 3'd4;
    localparam logic [2:0] W_BL_ON   = 3'd5;
    localparam logic [2:0] W_RW_CLR  = 3'd6;

    localparam logic [1:0] EX_NONE = 2'd0;
    localparam logic [1:0] EX_100  = 2'd1;
    localparam logic [1:0] EX_1000 = 2'd2;
    localparam logic [1:0] EX_5000 = 2'd3;

    localparam logic [12:0] WAIT_STROBE = 13'd50;

    localparam logic [7:0] ROW_OFFSET [4] = '{8'h00, 8'h40, 8'h10, 8'h50};

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] value;
        logic [2:0] row;
    } item_t;

    typedef struct packed {
        logic [7:0]  bus_address;
        logic [7:0]  port_byte;
        logic [12:0] wait_us;
        logic        last;
    } result_t;

    typedef struct packed {
        logic       load;
        logic       emit;
        logic [2:0] kind;
        logic       rs_data;
        logic       nib_item;
        logic       nib_lo;
        logic [3:0] nib_const;
        logic [1:0] extra;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic [2:0] item_kind;
        logic       out_free;
    } status_t;

    function automatic logic [12:0] extra_wait(input logic [1:0] code);
        logic [12:0] w;
        case (code)
            EX_100:  w = 13'd100;
            EX_1000: w = 13'd1000;
            EX_5000: w = 13'd5000;
            default: w = 13'd0;
        endcase
        return w;
    endfunction

endpackage

@@ src/clns_datapath.sv @@
// Datapath of the nibble sequencer: control shadow, item byte, address register
// and the result register. Depends on clns_pkg and takes commands from clns_controller.
module clns_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  clns_pkg::item_t   item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_data,
    output logic              result_valid,
    input  logic              result_ready,
    output clns_pkg::result_t result,
    input  clns_pkg::cmd_t    cmd,
    output clns_pkg::status_t status
);
    import clns_pkg::*;

    logic [3:0] shadow_reg, shadow_next;
    logic [7:0] byte_reg, byte_next;
    logic [7:0] addr_reg;
    logic       valid_reg, valid_next;
    result_t    result_reg, result_next;
    logic [3:0] nibble;
    logic [3:0] data_nib;
    logic [12:0] wait_val;
    logic [7:0] pos_sum;

    assign cfg_ready    = 1'b1;
    assign result_valid = valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        status.out_free = !valid_reg || result_ready;
        case (item.opcode)
            OP_INIT:      status.item_kind = K_INIT;
            OP_COMMAND:   status.item_kind = K_CMD;
            OP_DATA:      status.item_kind = K_DATA;
            OP_POSITION:  status.item_kind = item.row[2] ? K_NONE : K_CMD;
            OP_BACKLIGHT: status.item_kind = (item.value inside {8'd0, 8'd1}) ? K_BL : K_NONE;
            OP_CLEAR:     status.item_kind = K_CLEAR;
            default:      status.item_kind = K_NONE;
        endcase
    end

    always_comb
    begin
        pos_sum = ROW_OFFSET[item.row[1:0]] + item.value;
        case (item.opcode)
            OP_POSITION: byte_next = pos_sum | 8'h80;
            OP_CLEAR:    byte_next = 8'h01;
            default:     byte_next = item.value;
        endcase
        if (!cmd.load)
        begin
            byte_next = byte_reg;
        end
    end

    always_comb
    begin
        if (cmd.nib_item)
        begin
            nibble = cmd.nib_lo ? byte_reg[3:0] : byte_reg[7:4];
        end
        else
        begin
            nibble = cmd.nib_const;
        end
        shadow_next = shadow_reg;
        data_nib    = 4'h0;
        wait_val    = 13'd0;
        case (cmd.kind)
            W_RS:      shadow_next = cmd.rs_data ? (shadow_reg | SH_RS) : (shadow_reg & ~SH_RS);
            W_ERISE:
            begin
                shadow_next = shadow_reg | SH_E;
                wait_val    = WAIT_STROBE;
            end
            W_PUT:     data_nib = nibble;
            W_EFALL:
            begin
                shadow_next = shadow_reg & ~SH_E;
                data_nib    = nibble;
                wait_val    = WAIT_STROBE + extra_wait(cmd.extra);
            end
            W_BL_ITEM: shadow_next = byte_reg[0] ? (shadow_reg | SH_BL) : (shadow_reg & ~SH_BL);
            W_BL_ON:   shadow_next = shadow_reg | SH_BL;
            W_RW_CLR:  shadow_next = shadow_reg & ~SH_RW;
            default:   shadow_next = shadow_reg;
        endcase
        result_next.bus_address = addr_reg;
        result_next.port_byte   = {data_nib, shadow_next};
        result_next.wait_us     = wait_val;
        result_next.last        = cmd.last;
        if (cmd.emit)
        begin
            valid_next = 1'b1;
        end
        else
        begin
            valid_next = valid_reg && !result_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_reg <= 4'h0;
            addr_reg   <= EXPANDER_ADDRESS_RESET;
            valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cmd.emit)
            begin
                shadow_reg <= shadow_next;
            end
            if (cfg_valid)
            begin
                addr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        if (cmd.emit)
        begin
            result_reg <= result_next;
        end
    end

endmodule

@@ src/clns_controller.sv @@
// Controller of the nibble sequencer: steps through the writes of each word.
// Depends on clns_pkg and drives clns_datapath through cmd_t and status_t.
module clns_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  clns_pkg::status_t status,
    output clns_pkg::cmd_t    cmd
);
    import clns_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RS   = 3'd1;
    localparam logic [2:0] ST_RISE = 3'd2;
    localparam logic [2:0] ST_PUT  = 3'd3;
    localparam logic [2:0] ST_FALL = 3'd4;
    localparam logic [2:0] ST_BL   = 3'd5;
    localparam logic [2:0] ST_RW   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [2:0] kind_reg, kind_next;
    logic [2:0] seq_reg, seq_next;
    logic       lo_reg, lo_next;
    logic       is_init;

    assign item_ready = (state_reg == ST_IDLE);
    assign is_init    = (kind_reg == K_INIT);

    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        seq_next      = seq_reg;
        lo_next       = lo_reg;
        cmd.load      = 1'b0;
        cmd.emit      = 1'b0;
        cmd.kind      = W_RS;
        cmd.rs_data   = (kind_reg == K_DATA);
        cmd.nib_item  = !is_init;
        cmd.nib_lo    = lo_reg;
        cmd.extra     = EX_NONE;
        cmd.last      = 1'b0;
        case (seq_reg)
            3'd0, 3'd1, 3'd2: cmd.nib_const = 4'h3;
            3'd3:             cmd.nib_const = 4'h2;
            3'd4:             cmd.nib_const = lo_reg ? 4'h8 : 4'h2;
            3'd5:             cmd.nib_const = lo_reg ? 4'hE : 4'h0;
            default:          cmd.nib_const = 4'h0;
        endcase

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load  = 1'b1;
                    kind_next = status.item_kind;
                    seq_next  = 3'd0;
                    lo_next   = 1'b0;
                    case (status.item_kind)
                        K_NONE:  state_next = ST_IDLE;
                        K_INIT:  state_next = ST_RISE;
                        K_BL:    state_next = ST_BL;
                        default: state_next = ST_RS;
                    endcase
                end
            end
            ST_RS:
            begin
                cmd.kind = W_RS;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_RISE;
                end
            end
            ST_RISE:
            begin
                cmd.kind = W_ERISE;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                cmd.kind = W_PUT;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_FALL;
                end
            end
            ST_FALL:
            begin
                cmd.kind = W_EFALL;
                if (is_init && seq_reg < 3'd4)
                begin
                    case (seq_reg)
                        3'd0:    cmd.extra = EX_5000;
                        3'd1:    cmd.extra = EX_100;
                        default: cmd.extra = EX_1000;
                    endcase
                    if (status.out_free)
                    begin
                        seq_next   = seq_reg + 3'd1;
                        state_next = (seq_reg == 3'd3) ? ST_RS : ST_RISE;
                    end
                end
                else if (!lo_reg)
                begin
                    if (status.out_free)
                    begin
                        lo_next    = 1'b1;
                        state_next = ST_RISE;
                    end
                end
                else if (is_init)
                begin
                    cmd.extra = EX_1000;
                    if (status.out_free)
                    begin
                        lo_next    = 1'b0;
                        seq_next   = seq_reg + 3'd1;
                        state_next = (seq_reg == 3'd4) ? ST_RS : ST_BL;
                    end
                end
                else
                begin
                    cmd.extra = (kind_reg == K_CLEAR) ? EX_5000 : EX_NONE;
                    cmd.last  = 1'b1;
                    if (status.out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                cmd.emit = status.out_free;
            end
            ST_BL:
            begin
                if (is_init)
                begin
                    cmd.kind = W_BL_ON;
                    if (status.out_free)
                    begin
                        state_next = ST_RW;
                    end
                end
                else
                begin
                    cmd.kind = W_BL_ITEM;
                    cmd.last = 1'b1;
                    if (status.out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                cmd.emit = status.out_free;
            end
            ST_RW:
            begin
                cmd.kind = W_RW_CLR;
                cmd.last = 1'b1;
                cmd.emit = status.out_free;
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kind_reg  <= K_NONE;
            seq_reg   <= 3'd0;
            lo_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            seq_reg   <= seq_next;
            lo_reg    <= lo_next;
        end
    end

endmodule

@@ src/char_lcd_nibble_sequencer.sv @@
// Top level of the character LCD nibble sequencer (4-bit LCD behind a port expander).
// Depends on clns_pkg, clns_controller and clns_datapath.
//
// Usage:
//   The item channel (item_valid, item_ready, item) takes one LCD operation per word:
//   init, command byte, data byte, set position, backlight or clear.
//   The result channel (result_valid, result_ready, result) gives one expander port
//   write per word, with its bus address, port byte, the wait in microseconds that
//   must follow it, and last set on the final write of the operation.
//   The cfg channel (cfg_valid, cfg_ready, cfg_data) sets the expander bus address;
//   it is always ready and is meant to be written while the block is idle.
// Timing:
//   One operation is taken at a time. The first write passes the state register and
//   then the result register after the word is accepted, and one write follows per
//   cycle while the receiver takes them. A byte operation gives 7 writes, a
//   backlight change 1 write, init 28 writes, and an operation with no write none.
//   The pace is set by the single result register, which holds one write at a time.
// Reset and stall:
//   Reset clears the control shadow and restores address 0x4E. When the receiver
//   stalls, the pending write holds and the sequencer waits; no write is lost.
module char_lcd_nibble_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  clns_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output clns_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_data
);
    import clns_pkg::*;

    cmd_t    cmd;
    status_t status;

    clns_controller u_controller (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    clns_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cmd          (cmd),
        .status       (status)
    );

endmodule
